// ===== rtl/core/tbpd_pkg.sv =====
`default_nettype none

package tbpd_pkg;

   // defaults for the top-level parameters
   localparam int COEF_FRAC_BITS_DEF  = 28;
   localparam int FREQ_ALPHA_Q16_DEF  = 16384;
   localparam int PEAK_TIMEOUT_MS_DEF = 500;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int TIME_W     = 32;
   localparam int ENV_W      = 15;
   localparam int FREQ_W     = 16;
   localparam int CONF_W     = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // filter structure
   localparam int FILTER_TAPS = 5;
   localparam int HIST        = FILTER_TAPS - 1;
   localparam int HIST_IDX_W  = $clog2(HIST);
   localparam int Y_W         = 40;              // filter state, Q9.31
   localparam int YH_W        = 20;              // low part split off the state
   localparam int X_SHIFT     = 24;              // sample Q9.7 to state scale
   localparam int COEF_W      = 34;
   localparam int MOP_W       = 21;              // second multiplier operand
   localparam int PROD_W      = COEF_W + MOP_W;
   localparam int ACC_W       = 80;
   localparam int MAC_STEPS   = FILTER_TAPS + 2 * HIST;
   localparam int STEP_W      = $clog2(MAC_STEPS);
   localparam int ALPHA_SHIFT = 16;

   // shared divider
   localparam int DIV_W      = 22;
   localparam int DIV_DVS_W  = 16;
   localparam int FREQ_NUM   = 256000;           // 1000 Hz in Q8.8 times ms
   localparam int CONF_SCALE = 100;
   localparam int FREQ_MAX   = 65535;

   localparam int NUM_K [FILTER_TAPS] = '{134, 0, -267, 0, 134};
   localparam int DEN_K [FILTER_TAPS] = '{10000, -34183, 45883, -28577, 7009};

   typedef logic signed [COEF_W-1:0] coef_tab_type [MAC_STEPS];

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENV_ALPHA,
      CSR_TREMOR_THR,
      CSR_PEAK_THR,
      CSR_PEAK_RST_THR,
      CSR_MIN_PERIOD,
      CSR_MAX_PERIOD,
      CSR_LOW_FREQ,
      CSR_HIGH_FREQ
   } csr_idx_type;

   typedef enum logic [1:0] {
      MUL_MAC,
      MUL_ENV,
      MUL_FREQ
   } mul_sel_type;

   typedef struct packed {
      logic              load;
      mul_sel_type       mul_sel;
      logic [STEP_W-1:0] step;
      logic              acc_en;
      logic              filt_upd;
      logic              peak_upd;
      logic              env_upd;
      logic              div_start;
      logic              div_conf;
      logic              freq_upd;
      logic              tout;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic freq_hit;
      logic div_done;
   } status_type;

   // four-digit decimal coefficient, rounded half away from zero
   function automatic longint coef_fix(int k, int frac);
      longint m;
      longint v;
      m = (k < 0) ? -longint'(k) : longint'(k);
      v = ((m << frac) + 5000) / 10000;
      return (k < 0) ? -v : v;
   endfunction

   // numerator taps, then feedback taps for the high and the low state parts
   function automatic coef_tab_type coef_table(int frac);
      coef_tab_type t;
      for (int i = 0; i < FILTER_TAPS; i++) begin
         t[i] = COEF_W'(coef_fix(NUM_K[i], frac));
      end
      for (int j = 0; j < HIST; j++) begin
         t[FILTER_TAPS + j]        = COEF_W'(-coef_fix(DEN_K[j + 1], frac));
         t[FILTER_TAPS + HIST + j] = COEF_W'(-coef_fix(DEN_K[j + 1], frac));
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tbpd_div.sv =====
`default_nettype none

module tbpd_div
   import tbpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_W-1:0]     dividend,
   input  wire logic [DIV_DVS_W-1:0] divisor,
   output logic                      done,
   output logic [DIV_W-1:0]          quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_DVS_W-1:0] rem_ff;
   logic [DIV_DVS_W-1:0] dvs_ff;
   logic [DIV_DVS_W:0]   trial;
   logic                 fits;

   // one quotient bit per cycle, restoring
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // operands and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? DIV_DVS_W'(trial - {1'b0, dvs_ff}) : DIV_DVS_W'(trial);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tbpd_ctrl.sv =====
`default_nettype none

module tbpd_ctrl
   import tbpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_MAC, S_DRAIN, S_FILT, S_ENVM, S_ENVU,
      S_DIVF, S_FMUL, S_FUPD, S_TOUT, S_DIVC, S_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mul_sel  = MUL_MAC;
      cmd.step     = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.acc_en = (step_ff != '0);
            if (step_ff == STEP_W'(MAC_STEPS - 1)) begin
               state_in = S_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            cmd.acc_en = 1'b1;
            state_in   = S_FILT;
         end
         S_FILT: begin
            cmd.filt_upd = 1'b1;
            state_in     = S_ENVM;
         end
         S_ENVM: begin
            cmd.mul_sel  = MUL_ENV;
            cmd.peak_upd = 1'b1;
            state_in     = S_ENVU;
         end
         S_ENVU: begin
            cmd.env_upd = 1'b1;
            if (status.freq_hit) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVF;
            end else begin
               state_in = S_TOUT;
            end
         end
         S_DIVF: begin
            if (status.div_done) begin
               state_in = S_FMUL;
            end
         end
         S_FMUL: begin
            cmd.mul_sel = MUL_FREQ;
            state_in    = S_FUPD;
         end
         S_FUPD: begin
            cmd.freq_upd = 1'b1;
            state_in     = S_TOUT;
         end
         S_TOUT: begin
            cmd.tout      = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_conf  = 1'b1;
            state_in      = S_DIVC;
         end
         S_DIVC: begin
            if (status.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tbpd_dp.sv =====
`default_nettype none

module tbpd_dp
   import tbpd_pkg::*;
#(
   parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
   parameter int FREQ_ALPHA_Q16  = FREQ_ALPHA_Q16_DEF,
   parameter int PEAK_TIMEOUT_MS = PEAK_TIMEOUT_MS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic signed [SAMPLE_W-1:0] req_wrist_pitch,
   input  wire logic [TIME_W-1:0]     req_time_ms,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic signed [SAMPLE_W-1:0] rsp_filtered_pitch,
   output logic [ENV_W-1:0]           rsp_envelope_level,
   output logic [FREQ_W-1:0]          rsp_tremor_frequency,
   output logic [CONF_W-1:0]          rsp_confidence_pct,
   output logic                       rsp_tremor_detected
);

   localparam coef_tab_type COEF_TAB = coef_table(COEF_FRAC_BITS);
   localparam int Y_HI_FIRST = FILTER_TAPS;
   localparam int Y_LO_FIRST = FILTER_TAPS + HIST;
   localparam int SH_W = $clog2(X_SHIFT + 1);
   localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
   localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

   typedef enum logic [1:0] {
      PH_RISE,
      PH_TRACK,
      PH_RESET
   } phase_type;

   // configuration registers
   logic [CSR_DATA_W-1:0]       env_alpha_ff;
   logic [ENV_W-1:0]            tremor_thr_ff;
   logic signed [SAMPLE_W-1:0]  peak_thr_ff;
   logic signed [SAMPLE_W-1:0]  peak_rst_thr_ff;
   logic [CSR_DATA_W-1:0]       min_period_ff;
   logic [CSR_DATA_W-1:0]       max_period_ff;
   logic [FREQ_W-1:0]           low_freq_ff;
   logic [FREQ_W-1:0]           high_freq_ff;

   // sample and filter state
   logic signed [SAMPLE_W-1:0]  x_ff;
   logic [TIME_W-1:0]           now_ff;
   logic signed [SAMPLE_W-1:0]  xh_ff [HIST];
   logic signed [Y_W-1:0]       yh_ff [HIST];
   logic signed [PROD_W-1:0]    prod_ff;
   logic [SH_W-1:0]             sh_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [SAMPLE_W-1:0]  filt_ff;
   logic [ENV_W-1:0]            env_ff;
   logic [FREQ_W-1:0]           freq_ff;
   phase_type                   phase_ff;
   logic signed [SAMPLE_W-1:0]  prev_ff;
   logic [TIME_W-1:0]           last_ff;
   logic                        seen_ff;
   logic [DIV_DVS_W-1:0]        period_ff;
   logic                        freq_hit_ff;

   // result register
   logic signed [SAMPLE_W-1:0]  out_filt_ff;
   logic [ENV_W-1:0]            out_env_ff;
   logic [FREQ_W-1:0]           out_freq_ff;
   logic [CONF_W-1:0]           out_conf_ff;
   logic                        out_det_ff;

   logic signed [COEF_W-1:0]    op_a;
   logic signed [MOP_W-1:0]     op_b;
   logic signed [PROD_W-1:0]    mul_out;
   logic [SH_W-1:0]             sh_sel;
   logic [HIST_IDX_W-1:0]       x_idx;
   logic [HIST_IDX_W-1:0]       y_idx;
   logic signed [Y_W-1:0]       y_tap;
   logic signed [ACC_W-1:0]     acc_sh;
   logic [ACC_W-Y_W:0]          acc_top;
   logic signed [Y_W-1:0]       y_new;
   logic [ENV_W:0]              mag;
   logic [ENV_W-1:0]            mag_sat;
   logic signed [ENV_W+1:0]     env_diff;
   logic signed [ENV_W+1:0]     env_sum;
   logic [TIME_W-1:0]           period;
   logic                        in_range;
   logic                        peak_now;
   logic [DIV_W-1:0]            div_dividend;
   logic [DIV_DVS_W-1:0]        div_divisor;
   logic                        div_done;
   logic [DIV_W-1:0]            quotient;
   logic [FREQ_W-1:0]           meas;
   logic signed [FREQ_W:0]      freq_diff;
   logic signed [FREQ_W:0]      freq_sum;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         env_alpha_ff    <= CSR_DATA_W'(7209);
         tremor_thr_ff   <= ENV_W'(64);
         peak_thr_ff     <= SAMPLE_W'(64);
         peak_rst_thr_ff <= '0;
         min_period_ff   <= CSR_DATA_W'(100);
         max_period_ff   <= CSR_DATA_W'(300);
         low_freq_ff     <= FREQ_W'(1024);
         high_freq_ff    <= FREQ_W'(2048);
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_ENV_ALPHA:    env_alpha_ff    <= csr_wdata;
            CSR_TREMOR_THR:   tremor_thr_ff   <= csr_wdata[ENV_W-1:0];
            CSR_PEAK_THR:     peak_thr_ff     <= $signed(csr_wdata);
            CSR_PEAK_RST_THR: peak_rst_thr_ff <= $signed(csr_wdata);
            CSR_MIN_PERIOD:   min_period_ff   <= csr_wdata;
            CSR_MAX_PERIOD:   max_period_ff   <= csr_wdata;
            CSR_LOW_FREQ:     low_freq_ff     <= csr_wdata;
            CSR_HIGH_FREQ:    high_freq_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // history taps picked by the step
   assign x_idx = HIST_IDX_W'(cmd.step - 1'b1);
   assign y_idx = (cmd.step >= STEP_W'(Y_LO_FIRST)) ? HIST_IDX_W'(cmd.step - STEP_W'(Y_LO_FIRST))
                                                    : HIST_IDX_W'(cmd.step - STEP_W'(Y_HI_FIRST));
   assign y_tap = yh_ff[y_idx];

   // magnitude and envelope difference
   assign mag      = filt_ff[SAMPLE_W-1] ? (ENV_W+1)'(-filt_ff) : (ENV_W+1)'(filt_ff);
   assign mag_sat  = mag[ENV_W] ? {ENV_W{1'b1}} : mag[ENV_W-1:0];
   assign env_diff = $signed({2'b00, mag_sat}) - $signed({2'b00, env_ff});

   // measured frequency, saturated
   assign meas      = (quotient > DIV_W'(FREQ_MAX)) ? FREQ_W'(FREQ_MAX) : quotient[FREQ_W-1:0];
   assign freq_diff = $signed({1'b0, meas}) - $signed({1'b0, freq_ff});

   // shared multiplier operands
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      sh_sel = '0;
      case (cmd.mul_sel)
         MUL_MAC: begin
            op_a = (cmd.step < STEP_W'(MAC_STEPS)) ? COEF_TAB[cmd.step] : '0;
            if (cmd.step < STEP_W'(Y_HI_FIRST)) begin
               op_b   = (cmd.step == '0) ? MOP_W'(x_ff) : MOP_W'(xh_ff[x_idx]);
               sh_sel = SH_W'(X_SHIFT);
            end else if (cmd.step < STEP_W'(Y_LO_FIRST)) begin
               // high part of the state is signed
               op_b   = MOP_W'($signed(y_tap[Y_W-1:YH_W]));
               sh_sel = SH_W'(YH_W);
            end else begin
               op_b = $signed({1'b0, y_tap[YH_W-1:0]});
            end
         end
         MUL_ENV: begin
            op_a = $signed({{(COEF_W-CSR_DATA_W){1'b0}}, env_alpha_ff});
            op_b = MOP_W'(env_diff);
         end
         MUL_FREQ: begin
            op_a = COEF_W'(FREQ_ALPHA_Q16);
            op_b = MOP_W'(freq_diff);
         end
         default: ;
      endcase
   end

   assign mul_out = op_a * op_b;

   // filter output from the accumulator, floor and saturate
   assign acc_sh  = acc_ff >>> COEF_FRAC_BITS;
   assign acc_top = acc_sh[ACC_W-1:Y_W-1];
   assign y_new   = ((&acc_top) || !(|acc_top)) ? acc_sh[Y_W-1:0]
                                                : (acc_sh[ACC_W-1] ? Y_MIN : Y_MAX);

   assign env_sum  = $signed({2'b00, env_ff}) + (ENV_W+2)'(prod_ff >>> ALPHA_SHIFT);
   assign freq_sum = $signed({1'b0, freq_ff}) + (FREQ_W+1)'(prod_ff >>> ALPHA_SHIFT);

   // peak timing
   assign period   = now_ff - last_ff;
   assign in_range = (period >= TIME_W'(min_period_ff)) && (period <= TIME_W'(max_period_ff));
   assign peak_now = (phase_ff == PH_TRACK) && (filt_ff < prev_ff);

   // datapath payload
   always_ff @(posedge clock) begin
      prod_ff <= mul_out;
      sh_ff   <= sh_sel;
      if (cmd.load) begin
         x_ff   <= req_wrist_pitch;
         now_ff <= req_time_ms;
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + (ACC_W'(prod_ff) <<< sh_ff);
      end
      if (cmd.filt_upd) begin
         filt_ff <= y_new[Y_W-1:X_SHIFT];
      end
      if (cmd.peak_upd) begin
         period_ff <= period[DIV_DVS_W-1:0];
      end
      if (cmd.out_load) begin
         out_filt_ff <= filt_ff;
         out_env_ff  <= env_ff;
         out_freq_ff <= freq_ff;
         out_conf_ff <= (quotient > DIV_W'(CONF_SCALE)) ? CONF_W'(CONF_SCALE)
                                                       : quotient[CONF_W-1:0];
         out_det_ff  <= (env_ff >= tremor_thr_ff) && (freq_ff >= low_freq_ff)
                        && (freq_ff <= high_freq_ff);
      end
   end

   // filter history, envelope, frequency and peak tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
         env_ff      <= '0;
         freq_ff     <= '0;
         phase_ff    <= PH_RISE;
         prev_ff     <= '0;
         last_ff     <= '0;
         seen_ff     <= 1'b0;
         freq_hit_ff <= 1'b0;
      end else begin
         if (cmd.filt_upd) begin
            for (int i = HIST - 1; i > 0; i--) begin
               xh_ff[i] <= xh_ff[i - 1];
               yh_ff[i] <= yh_ff[i - 1];
            end
            xh_ff[0] <= x_ff;
            yh_ff[0] <= y_new;
         end
         if (cmd.env_upd) begin
            env_ff <= env_sum[ENV_W-1:0];
         end
         if (cmd.peak_upd) begin
            freq_hit_ff <= peak_now && seen_ff && in_range;
            prev_ff     <= filt_ff;
            case (phase_ff)
               PH_TRACK: begin
                  if (peak_now) begin
                     last_ff  <= now_ff;
                     seen_ff  <= 1'b1;
                     phase_ff <= PH_RESET;
                  end
               end
               PH_RESET: begin
                  if (filt_ff < peak_rst_thr_ff) begin
                     phase_ff <= PH_RISE;
                  end
               end
               default: begin
                  phase_ff <= (filt_ff > peak_thr_ff) ? PH_TRACK : PH_RISE;
               end
            endcase
         end
         if (cmd.freq_upd) begin
            freq_ff <= freq_sum[FREQ_W-1:0];
         end else if (cmd.tout && seen_ff && (period > TIME_W'(PEAK_TIMEOUT_MS))) begin
            freq_ff <= '0;
         end
      end
   end

   // divider operands: peak frequency or confidence
   assign div_dividend = cmd.div_conf ? DIV_W'(env_ff) * DIV_W'(CONF_SCALE) : DIV_W'(FREQ_NUM);
   assign div_divisor  = cmd.div_conf ? DIV_DVS_W'(tremor_thr_ff) : period_ff;

   tbpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status.freq_hit = freq_hit_ff;
   assign status.div_done = div_done;

   assign rsp_filtered_pitch   = out_filt_ff;
   assign rsp_envelope_level   = out_env_ff;
   assign rsp_tremor_frequency = out_freq_ff;
   assign rsp_confidence_pct   = out_conf_ff;
   assign rsp_tremor_detected  = out_det_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tremor_bandpass_peak_detector.sv =====
// Channel   Handshake              Beat contents
// req       req_valid/req_ready    wrist pitch sample (Q9.7), timestamp in ms
// rsp       rsp_valid/rsp_ready    filtered pitch, envelope, frequency, confidence, flag
// csr       csr_wr_en              register index and write data, no wait
//
// Each sample runs through the shared filter multiply-accumulate and then one
// or two bit-serial divider passes of 22 steps each, two when a peak period is
// measured. A new sample is taken only while the sequencer is idle, so a sample
// is accepted only after the one before it has been processed; a finished result
// waits in the output register, and the next sample may start meanwhile.
// Reset is synchronous and clears filter history, tracker state and configuration registers.
`default_nettype none

module tremor_bandpass_peak_detector
   import tbpd_pkg::*;
#(
   parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DEF,
   parameter int FREQ_ALPHA_Q16  = FREQ_ALPHA_Q16_DEF,
   parameter int PEAK_TIMEOUT_MS = PEAK_TIMEOUT_MS_DEF
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_wrist_pitch,
   input  wire logic [TIME_W-1:0]          req_time_ms,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_filtered_pitch,
   output logic [ENV_W-1:0]                rsp_envelope_level,
   output logic [FREQ_W-1:0]               rsp_tremor_frequency,
   output logic [CONF_W-1:0]               rsp_confidence_pct,
   output logic                            rsp_tremor_detected,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tbpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tbpd_dp #(
      .COEF_FRAC_BITS  (COEF_FRAC_BITS),
      .FREQ_ALPHA_Q16  (FREQ_ALPHA_Q16),
      .PEAK_TIMEOUT_MS (PEAK_TIMEOUT_MS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_wrist_pitch      (req_wrist_pitch),
      .req_time_ms          (req_time_ms),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_filtered_pitch   (rsp_filtered_pitch),
      .rsp_envelope_level   (rsp_envelope_level),
      .rsp_tremor_frequency (rsp_tremor_frequency),
      .rsp_confidence_pct   (rsp_confidence_pct),
      .rsp_tremor_detected  (rsp_tremor_detected)
   );

   // a sample is latched only on an accepted beat
   assert property (@(posedge clock) disable iff (reset) cmd.load |-> req_valid && req_ready)
      else $error("sample latched without an accepted beat");

   // a result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
                    cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   // a loaded result is offered in the next cycle
   assert property (@(posedge clock) disable iff (reset) cmd.out_load |=> rsp_valid)
      else $error("loaded result not offered");

   // the divider cannot finish the cycle after it starts
   assert property (@(posedge clock) disable iff (reset) cmd.div_start |=> !status.div_done)
      else $error("divider done too early");

endmodule

`default_nettype wire
